// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
	else $error("assertion failed")

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion failed")

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/lvjd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lvjd_pkg;

	localparam int WIN_DEPTH = 11;
	localparam int HDR_LEN = WIN_DEPTH + 1;

	localparam logic [7:0] MARK_FF = 8'hFF;
	localparam logic [7:0] MARK_SOI = 8'hD8;

	localparam logic CFG_MAGIC = 1'b0;
	localparam logic CFG_OFFSET = 1'b1;

	localparam logic [31:0] MAGIC_RESET = 32'h2435_6879;
	localparam logic [7:0] OFFSET_RESET = 8'd136;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t res0;
		res_t res1;
	} step_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lvjd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lvjd_parser #(
	parameter int SIZE_BYTES = 3
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire logic [7:0] data_byte,
	input wire logic [31:0] header_magic,
	input wire logic [7:0] image_offset,
	output lvjd_pkg::step_t step
);

	typedef enum logic [1:0] {
		MODE_SCAN = 2'd0,
		MODE_SKIP = 2'd1,
		MODE_EMIT = 2'd2
	} mode_t;

	localparam logic [7:0] HDR_LEN_B = 8'(lvjd_pkg::HDR_LEN);
	localparam logic [7:0] SIZE_END = 8'(lvjd_pkg::HDR_LEN + SIZE_BYTES);

	mode_t mode_q, mode_d;
	logic [7:0] win_q [lvjd_pkg::WIN_DEPTH];
	logic [7:0] hpos_q, hpos_d;
	logic [23:0] size_q, size_d;
	logic [23:0] rem_q, rem_d;
	logic prev_q, prev_d;
	logic [7:0] hpos_inc;
	logic marker;
	logic header;

	always_comb begin
		mode_d = mode_q;
		hpos_d = hpos_q;
		size_d = size_q;
		rem_d = rem_q;
		prev_d = prev_q;
		step = '0;
		hpos_inc = (hpos_q < HDR_LEN_B) ? hpos_q + 8'd1 : hpos_q;
		marker = (size_q != '0) && prev_q && (win_q[0] == lvjd_pkg::MARK_FF)
			&& (data_byte == lvjd_pkg::MARK_SOI);
		header = (hpos_inc >= HDR_LEN_B)
			&& (win_q[lvjd_pkg::WIN_DEPTH - 1] == lvjd_pkg::MARK_FF)
			&& (win_q[2] == header_magic[31:24])
			&& (win_q[1] == header_magic[23:16])
			&& (win_q[0] == header_magic[15:8])
			&& (data_byte == header_magic[7:0]);
		case (mode_q)
			MODE_SKIP: begin
				if (hpos_q >= HDR_LEN_B && hpos_q < SIZE_END) begin
					size_d = {size_q[15:0], data_byte};
				end
				if (hpos_q >= image_offset) begin
					mode_d = MODE_SCAN;
					prev_d = 1'b1;
					hpos_d = '0;
				end else begin
					hpos_d = hpos_q + 8'd1;
				end
			end
			MODE_EMIT: begin
				if (rem_q != '0) begin
					rem_d = rem_q - 24'd1;
				end
				step.count = 2'd1;
				step.res0.data = data_byte;
				step.res0.last = (rem_d == '0);
				if (rem_d == '0) begin
					mode_d = MODE_SCAN;
					hpos_d = '0;
					prev_d = 1'b0;
					size_d = '0;
				end
			end
			default: begin
				mode_d = MODE_SCAN;
				hpos_d = hpos_inc;
				if (marker) begin
					step.res0.data = lvjd_pkg::MARK_FF;
					if (size_q == 24'd1) begin
						step.count = 2'd1;
						step.res0.last = 1'b1;
						size_d = '0;
						hpos_d = 8'd1;
						prev_d = 1'b1;
					end else begin
						step.count = 2'd2;
						step.res1.data = lvjd_pkg::MARK_SOI;
						step.res1.last = (size_q == 24'd2);
						if (size_q == 24'd2) begin
							hpos_d = '0;
							prev_d = 1'b0;
							size_d = '0;
							rem_d = '0;
						end else begin
							rem_d = size_q - 24'd2;
							mode_d = MODE_EMIT;
						end
					end
				end else if (header) begin
					mode_d = MODE_SKIP;
					size_d = '0;
					hpos_d = HDR_LEN_B;
					prev_d = 1'b0;
				end else begin
					prev_d = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SCAN;
			hpos_q <= '0;
			size_q <= '0;
			rem_q <= '0;
			prev_q <= 1'b0;
			for (int i = 0; i < lvjd_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (fire) begin
			mode_q <= mode_d;
			hpos_q <= hpos_d;
			size_q <= size_d;
			rem_q <= rem_d;
			prev_q <= prev_d;
			win_q[0] <= data_byte;
			for (int i = 1; i < lvjd_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= win_q[i - 1];
			end
		end
	end

	// While an image is streaming at least one byte is always still owed.
	`ASSERT_ALWAYS(a_emit_rem, clk, arst_n, (mode_q != MODE_EMIT) || (rem_q != '0));
	`ASSERT_ALWAYS(a_hpos_bound, clk, arst_n, (mode_q == MODE_SKIP) || (hpos_q <= HDR_LEN_B));
	`ASSERT_NEXT(a_emit_done, clk, arst_n,
		fire && (mode_q == MODE_EMIT) && step.res0.last, mode_q == MODE_SCAN);

endmodule

`default_nettype wire

// ----- hw/rtl/lvjd_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lvjd_result_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire lvjd_pkg::step_t step,
	output logic room,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] image_byte,
	output logic image_last
);

	lvjd_pkg::res_t mem_q [lvjd_pkg::FIFO_DEPTH];
	logic [lvjd_pkg::PTR_W-1:0] wptr_q, rptr_q;
	logic [lvjd_pkg::CNT_W-1:0] count_q;
	logic [lvjd_pkg::CNT_W-1:0] push_n;
	logic [lvjd_pkg::CNT_W:0] count_sum;
	logic pop;

	assign out_valid = (count_q != '0);
	assign pop = out_valid && !out_stall;
	assign push_n = push ? lvjd_pkg::CNT_W'(step.count) : '0;
	assign count_sum = {1'b0, count_q} + {1'b0, push_n} - (lvjd_pkg::CNT_W + 1)'(pop);
	// A step may bring two items, so two slots must be free after this cycle's pop.
	assign room = (count_q - lvjd_pkg::CNT_W'(pop)) <= lvjd_pkg::CNT_W'(lvjd_pkg::FIFO_DEPTH - 2);
	assign image_byte = mem_q[rptr_q].data;
	assign image_last = mem_q[rptr_q].last;

	always_ff @(posedge clk) begin
		if (push && step.count != 2'd0) begin
			mem_q[wptr_q] <= step.res0;
		end
		if (push && step.count == 2'd2) begin
			mem_q[wptr_q + lvjd_pkg::PTR_W'(1)] <= step.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + lvjd_pkg::PTR_W'(push_n);
			rptr_q <= rptr_q + lvjd_pkg::PTR_W'(pop);
			count_q <= lvjd_pkg::CNT_W'(count_sum);
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, count_sum <= (lvjd_pkg::CNT_W + 1)'(lvjd_pkg::FIFO_DEPTH));
	`ASSERT_ALWAYS(a_push_room, clk, arst_n, !push || (step.count == 2'd0) || room);

endmodule

`default_nettype wire

// ----- hw/rtl/liveview_jpeg_deframer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Extracts JPEG images from a live-view byte stream, one byte per cycle while the input
// is not stalled. A byte is taken into an input register, parsed from there once the
// four-entry result queue has room for two items, and its results are written into that
// queue, whose head entry drives the output. Most bytes give zero or one result item;
// the byte that completes an FF D8 start marker gives up to two (FF and D8), which leave
// the queue one after the other. The input is stalled only while the queue would have
// fewer than two free entries after the current cycle's departure, so with an output
// side that never stalls the block takes one byte every cycle. Configuration registers
// are written through the cfg port, which is always ready, and should only be written
// while no item is pending.

module liveview_jpeg_deframer_unit #(
	parameter int SIZE_BYTES = 3
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] image_byte,
	output logic image_last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data
);

	logic [31:0] magic_q;
	logic [7:0] offset_q;
	logic valid_s1;
	logic [7:0] data_s1;
	logic room;
	logic fire;
	lvjd_pkg::step_t step;

	assign cfg_ready = 1'b1;
	assign fire = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= lvjd_pkg::MAGIC_RESET;
			offset_q <= lvjd_pkg::OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lvjd_pkg::CFG_MAGIC: magic_q <= cfg_data;
				lvjd_pkg::CFG_OFFSET: offset_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && !in_stall) || in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	lvjd_parser #(
		.SIZE_BYTES(SIZE_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.data_byte(data_s1),
		.header_magic(magic_q),
		.image_offset(offset_q),
		.step(step)
	);

	lvjd_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fire),
		.step(step),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.image_byte(image_byte),
		.image_last(image_last)
	);

endmodule

`default_nettype wire
